// ===== design/rgbop_pkg.sv =====
// Shared constants, types and fixed-point coefficients for the RGB to opponent converter.
package rgbop_pkg;

  localparam int COEF_FRAC_BITS = 16;
  localparam int PIX_W          = 8;
  localparam int CH_W           = 13;
  localparam int CH_LIMIT       = 4095;
  localparam int PIPE_DEPTH     = 4;

  // Sign bit plus five integer bits above the fraction.
  localparam int COEF_W = COEF_FRAC_BITS + 6;
  // Signed coefficient times a zero-extended pixel.
  localparam int PROD_W = COEF_W + PIX_W + 1;
  // Room for the sum of three products.
  localparam int ACC_W  = PROD_W + 2;
  // Integer part after dropping the fraction.
  localparam int INT_W  = ACC_W - COEF_FRAC_BITS;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [CH_W-1:0]   chan_t;

  // Magnitude of each coefficient: round(mant * 273/17 * 2^F / 2^shift), ties away from zero.
  localparam longint unsigned KM0 =
    ((64'd14267344 * 64'd273 << COEF_FRAC_BITS) + (64'd17 << 25)) / (64'd17 << 26);
  localparam longint unsigned KM1 =
    ((64'd11999065 * 64'd273 << COEF_FRAC_BITS) + (64'd17 << 23)) / (64'd17 << 24);
  localparam longint unsigned KM2 =
    ((64'd9690466  * 64'd273 << COEF_FRAC_BITS) + (64'd17 << 26)) / (64'd17 << 27);
  localparam longint unsigned KM3 =
    ((64'd10901851 * 64'd273 << COEF_FRAC_BITS) + (64'd17 << 25)) / (64'd17 << 26);
  localparam longint unsigned KM4 =
    ((64'd9168653  * 64'd273 << COEF_FRAC_BITS) + (64'd17 << 23)) / (64'd17 << 24);
  localparam longint unsigned KM5 =
    ((64'd11894119 * 64'd273 << COEF_FRAC_BITS) + (64'd17 << 23)) / (64'd17 << 24);
  localparam longint unsigned KM6 =
    ((64'd16777161 * 64'd273 << COEF_FRAC_BITS) + (64'd17 << 23)) / (64'd17 << 24);
  localparam longint unsigned KM7 =
    ((64'd15238787 * 64'd273 << COEF_FRAC_BITS) + (64'd17 << 23)) / (64'd17 << 24);
  localparam longint unsigned KM8 =
    ((64'd12306871 * 64'd273 << COEF_FRAC_BITS) + (64'd17 << 26)) / (64'd17 << 27);

  localparam coef_t K_Y0  = coef_t'(KM0);
  localparam coef_t K_Y1  = coef_t'(KM1);
  localparam coef_t K_Y2  = coef_t'(KM2);
  localparam coef_t K_C10 = coef_t'(64'd0 - KM3);
  localparam coef_t K_C11 = coef_t'(64'd0 - KM4);
  localparam coef_t K_C12 = coef_t'(KM5);
  localparam coef_t K_C20 = coef_t'(KM6);
  localparam coef_t K_C21 = coef_t'(64'd0 - KM7);
  localparam coef_t K_C22 = coef_t'(64'd0 - KM8);

endpackage

// ===== design/rgb8_to_opponent_u12_matrix_core.sv =====
// Top level of the 8-bit RGB to 12-bit luma and opponent-color converter.
//
// Usage:
//   Request channel: drive red, green, blue and last_pixel with start high.
//   A request is taken at any rising edge where start is high and busy is
//   low. busy is high only while rst is high, so one pixel per clock is
//   accepted in normal operation.
//   Result channel: done is high for exactly one cycle with luma,
//   chroma_first, chroma_second and last_out valid; the result is taken at
//   the edge that ends that cycle. The receiver cannot stall, so no
//   backpressure exists and results are never held.
//   Pipeline: a taken request passes the input register, multiply, sum
//   and round/clamp registers in that order; done then shows its result.
//   Throughput: one pixel per clock, set by the four-stage pipeline of
//   three parallel row units, each with its own multipliers.
//   Reset: rst clears the valid bits of every stage, dropping any pixel in
//   flight; payload registers are not reset.
module rgb8_to_opponent_u12_matrix_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  logic                 last_pixel,
  output logic                 done,
  output logic signed [12:0]   luma,
  output logic signed [12:0]   chroma_first,
  output logic signed [12:0]   chroma_second,
  output logic                 last_out
);

  localparam int DEPTH = rgbop_pkg::PIPE_DEPTH;

  rgbop_pkg::pix_t  red_q, green_q, blue_q;
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] last_pipe;
  logic             accept;

  // Hold off requests only while the pipeline is being cleared.
  assign busy   = rst;
  assign accept = start && !busy;

  // Capture the request pixel.
  always_ff @(posedge clk) begin
    red_q   <= red;
    green_q <= green;
    blue_q  <= blue;
  end

  // Advance the valid bits alongside the data; drop everything on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], accept};
    end
  end

  // The last-pixel mark rides along unchanged.
  always_ff @(posedge clk) begin
    last_pipe <= {last_pipe[DEPTH-2:0], last_pixel};
  end

  rgbop_row u_row_luma (
    .clk   (clk),
    .red   (red_q),
    .green (green_q),
    .blue  (blue_q),
    .k0    (rgbop_pkg::K_Y0),
    .k1    (rgbop_pkg::K_Y1),
    .k2    (rgbop_pkg::K_Y2),
    .res   (luma)
  );

  rgbop_row u_row_c1 (
    .clk   (clk),
    .red   (red_q),
    .green (green_q),
    .blue  (blue_q),
    .k0    (rgbop_pkg::K_C10),
    .k1    (rgbop_pkg::K_C11),
    .k2    (rgbop_pkg::K_C12),
    .res   (chroma_first)
  );

  rgbop_row u_row_c2 (
    .clk   (clk),
    .red   (red_q),
    .green (green_q),
    .blue  (blue_q),
    .k0    (rgbop_pkg::K_C20),
    .k1    (rgbop_pkg::K_C21),
    .k2    (rgbop_pkg::K_C22),
    .res   (chroma_second)
  );

  assign done     = vld[DEPTH-1];
  assign last_out = last_pipe[DEPTH-1];

endmodule

// ===== design/rgbop_row.sv =====
// One matrix row: three multiplies, a sum, then round-half-even and clamp.
module rgbop_row (
  input  logic                  clk,
  input  rgbop_pkg::pix_t       red,
  input  rgbop_pkg::pix_t       green,
  input  rgbop_pkg::pix_t       blue,
  input  rgbop_pkg::coef_t      k0,
  input  rgbop_pkg::coef_t      k1,
  input  rgbop_pkg::coef_t      k2,
  output rgbop_pkg::chan_t      res
);

  localparam int F = rgbop_pkg::COEF_FRAC_BITS;

  logic signed [rgbop_pkg::PROD_W-1:0] prod0, prod1, prod2;
  logic signed [rgbop_pkg::ACC_W-1:0]  acc;
  logic signed [rgbop_pkg::INT_W-1:0]  q;
  logic signed [rgbop_pkg::INT_W:0]    q_rnd;
  logic        [F-1:0]                 rem;
  logic        [F-1:0]                 half;
  logic                                rnd_up;
  rgbop_pkg::chan_t                    res_next;

  // Stage: products.
  always_ff @(posedge clk) begin
    prod0 <= rgbop_pkg::PROD_W'(k0) * rgbop_pkg::PROD_W'($signed({1'b0, red}));
    prod1 <= rgbop_pkg::PROD_W'(k1) * rgbop_pkg::PROD_W'($signed({1'b0, green}));
    prod2 <= rgbop_pkg::PROD_W'(k2) * rgbop_pkg::PROD_W'($signed({1'b0, blue}));
  end

  // Stage: sum.
  always_ff @(posedge clk) begin
    acc <= rgbop_pkg::ACC_W'(prod0) + rgbop_pkg::ACC_W'(prod1) + rgbop_pkg::ACC_W'(prod2);
  end

  // Floor quotient and non-negative remainder; bump on more than half or odd tie.
  always_comb begin
    q      = acc[rgbop_pkg::ACC_W-1:F];
    rem    = acc[F-1:0];
    half   = F'(1) << (F - 1);
    rnd_up = (rem > half) || ((rem == half) && q[0]);
    q_rnd  = (rgbop_pkg::INT_W+1)'(q) + (rgbop_pkg::INT_W+1)'(rnd_up);
    if (q_rnd > (rgbop_pkg::INT_W+1)'(rgbop_pkg::CH_LIMIT)) begin
      res_next = rgbop_pkg::chan_t'(rgbop_pkg::CH_LIMIT);
    end else if (q_rnd < -(rgbop_pkg::INT_W+1)'(rgbop_pkg::CH_LIMIT)) begin
      res_next = -rgbop_pkg::chan_t'(rgbop_pkg::CH_LIMIT);
    end else begin
      res_next = q_rnd[rgbop_pkg::CH_W-1:0];
    end
  end

  // Stage: rounded and clamped result.
  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// ===== design/rgbop_checker.sv =====
// Port-level checks for the converter, bound to the top level.
module rgbop_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               last_pixel,
  input logic               done,
  input logic signed [12:0] luma,
  input logic signed [12:0] chroma_first,
  input logic signed [12:0] chroma_second,
  input logic               last_out
);

  // Every request yields its result once it has passed the pipeline.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("request produced no result");

  // No result appears without a matching request.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without request");

  // The last-pixel mark follows its pixel.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (last_out == $past(last_pixel, 4)))
    else $error("last mark out of step");

  // All channels stay inside the clamp limits.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (luma >= -13'sd4095 && luma <= 13'sd4095 &&
              chroma_first >= -13'sd4095 && chroma_first <= 13'sd4095 &&
              chroma_second >= -13'sd4095 && chroma_second <= 13'sd4095))
    else $error("channel outside clamp range");

endmodule

bind rgb8_to_opponent_u12_matrix_core rgbop_checker u_rgbop_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .last_pixel    (last_pixel),
  .done          (done),
  .luma          (luma),
  .chroma_first  (chroma_first),
  .chroma_second (chroma_second),
  .last_out      (last_out)
);
